// ===== hw/rtl/tch_pkg.sv =====
// Shared types, widths and constants for the tilt-compensated heading block.
// Used by tch_sincos, tch_atan2 and tilt_compensated_heading; depends on nothing.
package tch_pkg;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Angle ports are Q3.13; internal angles are Q30.
    localparam int ANGLE_W     = 16;
    localparam int ANGLE_SHIFT = 17;
    localparam int THETA_W     = ANGLE_W + ANGLE_SHIFT + 1;
    localparam int TRIG_W      = 33;
    localparam int ZACC_W      = 34;
    localparam int HEAD_W      = 36;
    localparam int OUT_W       = 16;

    localparam int TAB_LEN = 24;
    localparam logic [31:0] ATAN_Q30 [TAB_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    localparam logic signed [TRIG_W-1:0]  Q30_GAIN     = 33'sd652032874;
    localparam logic signed [THETA_W-1:0] T_HALF_PI    = 34'sd1686629713;
    localparam logic signed [THETA_W-1:0] T_PI         = 34'sd3373259426;
    localparam logic signed [HEAD_W-1:0]  H_PI         = 36'sd3373259426;
    localparam logic signed [HEAD_W-1:0]  H_TWO_PI     = 36'sd6746518852;
    localparam logic signed [HEAD_W-1:0]  H_THREE_PI   = 36'sd10119778278;
    localparam logic signed [HEAD_W-1:0]  H_ROUND_HALF = 36'sd65536;
    localparam logic [OUT_W-1:0]          HEADING_MAX  = 16'd51471;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_OFFSET_X = 2'd0;
    localparam cfg_index_t REG_OFFSET_Y = 2'd1;
    localparam cfg_index_t REG_OFFSET_Z = 2'd2;

endpackage

// ===== hw/rtl/tch_sincos.sv =====
// Pipelined rotation-mode CORDIC giving sine and cosine of a Q3.13 angle in Q30.
// Depends on tch_pkg for widths, the gain and the arctangent table.
module tch_sincos
    import tch_pkg::*;
#(
    parameter int STEPS = DEF_CORDIC_STEPS
)
(
    input  logic                       clk,
    input  logic signed [ANGLE_W-1:0]  angle,
    output logic signed [TRIG_W-1:0]   sin_val,
    output logic signed [TRIG_W-1:0]   cos_val
);

    logic signed [THETA_W-1:0] t_in;
    logic signed [THETA_W-1:0] t_reg [STEPS];
    logic signed [TRIG_W-1:0]  x_reg [STEPS+1];
    logic signed [TRIG_W-1:0]  y_reg [STEPS+1];
    logic                      neg_reg [STEPS+1];

    assign t_in = {angle[ANGLE_W-1], angle, {ANGLE_SHIFT{1'b0}}};

    // Angles past a quarter turn are folded by a half turn and the results negated.
    always_ff @(posedge clk)
    begin
        if (t_in > T_HALF_PI)
        begin
            t_reg[0]   <= t_in - T_PI;
            neg_reg[0] <= 1'b1;
        end
        else if (t_in < -T_HALF_PI)
        begin
            t_reg[0]   <= t_in + T_PI;
            neg_reg[0] <= 1'b1;
        end
        else
        begin
            t_reg[0]   <= t_in;
            neg_reg[0] <= 1'b0;
        end
        x_reg[0] <= Q30_GAIN;
        y_reg[0] <= '0;
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam logic signed [THETA_W-1:0] ATN = THETA_W'(ATAN_Q30[i]);
        always_ff @(posedge clk)
        begin
            if (t_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
            end
            neg_reg[i+1] <= neg_reg[i];
        end
        if (i < STEPS - 1)
        begin : g_theta
            always_ff @(posedge clk)
            begin
                if (t_reg[i] >= 0)
                    t_reg[i+1] <= t_reg[i] - ATN;
                else
                    t_reg[i+1] <= t_reg[i] + ATN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sin_val <= neg_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
        cos_val <= neg_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
    end

endmodule

// ===== hw/rtl/tch_atan2.sv =====
// Pipelined vectoring-mode CORDIC giving atan2(y, x) in Q30, moved into [0, 2*pi).
// Depends on tch_pkg for widths, pi multiples and the arctangent table.
module tch_atan2
    import tch_pkg::*;
#(
    parameter int STEPS = DEF_CORDIC_STEPS,
    parameter int VEC_W = DEF_SAMPLE_WIDTH + 39
)
(
    input  logic                      clk,
    input  logic signed [VEC_W-1:0]   y_in,
    input  logic signed [VEC_W-1:0]   x_in,
    output logic signed [HEAD_W-1:0]  angle
);

    logic signed [VEC_W-1:0]  x_reg [STEPS];
    logic signed [VEC_W-1:0]  y_reg [STEPS];
    logic signed [ZACC_W-1:0] z_reg [STEPS+1];
    logic signed [HEAD_W-1:0] bp_reg [STEPS+1];
    logic signed [HEAD_W-1:0] bn_reg [STEPS+1];
    logic                     zero_reg [STEPS+1];
    logic signed [HEAD_W-1:0] h_pos;
    logic signed [HEAD_W-1:0] h_neg;

    // A vector in the left half plane is turned by pi first. bn is the base plus 2*pi,
    // so the wrap of a negative angle needs no second add later.
    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (x_in == '0) && (y_in == '0);
        z_reg[0]    <= '0;
        if (x_in < 0)
        begin
            x_reg[0] <= -x_in;
            y_reg[0] <= -y_in;
            if (y_in >= 0)
            begin
                bp_reg[0] <= H_PI;
                bn_reg[0] <= H_THREE_PI;
            end
            else
            begin
                bp_reg[0] <= -H_PI;
                bn_reg[0] <= H_PI;
            end
        end
        else
        begin
            x_reg[0]  <= x_in;
            y_reg[0]  <= y_in;
            bp_reg[0] <= '0;
            bn_reg[0] <= H_TWO_PI;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam logic signed [ZACC_W-1:0] ATN = ZACC_W'(ATAN_Q30[i]);
        always_ff @(posedge clk)
        begin
            if (y_reg[i] < 0)
                z_reg[i+1] <= z_reg[i] - ATN;
            else
                z_reg[i+1] <= z_reg[i] + ATN;
            bp_reg[i+1]   <= bp_reg[i];
            bn_reg[i+1]   <= bn_reg[i];
            zero_reg[i+1] <= zero_reg[i];
        end
        if (i < STEPS - 1)
        begin : g_vec
            always_ff @(posedge clk)
            begin
                if (y_reg[i] < 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                end
            end
        end
    end

    assign h_pos = HEAD_W'(z_reg[STEPS]) + bp_reg[STEPS];
    assign h_neg = HEAD_W'(z_reg[STEPS]) + bn_reg[STEPS];

    always_ff @(posedge clk)
    begin
        if (zero_reg[STEPS])
            angle <= '0;
        else if (h_pos < 0)
            angle <= h_neg;
        else
            angle <= h_pos;
    end

endmodule

// ===== hw/rtl/tilt_compensated_heading.sv =====
// Top level of the tilt-compensated magnetic heading pipeline.
// Depends on tch_pkg, tch_sincos (roll and pitch trig) and tch_atan2 (heading angle).
//
// Usage: drive roll_angle, pitch_angle (signed Q3.13 radians) and field_x/y/z
// (signed raw magnetometer counts) and raise start for one cycle per transaction.
// busy is always low, so a new transaction is taken on every clock edge where
// start is high, back to back with no gaps.
// Each transaction produces exactly one heading (unsigned Q3.13 radians, 0 to just
// below 2*pi), shown on heading for a single cycle while done is high.
// The pipeline consists of the two unrolled CORDIC chains, one iteration per stage,
// plus the multiply and add stages that form the horizontal field terms.
// Throughput is one transaction per cycle; results leave in the order taken.
// The receiver cannot stall, so nothing is ever held back.
// The hard-iron offsets are written through cfg_write, cfg_index and cfg_data and
// should only change while no transaction is in flight.
// Reset clears the offsets to zero and drops every transaction in flight.
module tilt_compensated_heading
    import tch_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [ANGLE_W-1:0]      roll_angle,
    input  logic signed [ANGLE_W-1:0]      pitch_angle,
    input  logic signed [SAMPLE_WIDTH-1:0] field_x,
    input  logic signed [SAMPLE_WIDTH-1:0] field_y,
    input  logic signed [SAMPLE_WIDTH-1:0] field_z,
    input  logic                           cfg_write,
    input  cfg_index_t                     cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]        cfg_data,
    output logic                           done,
    output logic [OUT_W-1:0]               heading
);

    // Widths of the field path: offset-corrected sample, one product, the sums.
    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int PROD_W = DIFF_W + TRIG_W;
    localparam int PP_W   = 2 * TRIG_W;
    localparam int SUM_W  = SAMPLE_WIDTH + 36;
    localparam int VEC_W  = SUM_W + 3;
    localparam int DLY    = CORDIC_STEPS + 2;
    localparam int LAT    = 2 * CORDIC_STEPS + 8;
    localparam int RND_W  = HEAD_W - ANGLE_SHIFT;

    logic signed [SAMPLE_WIDTH-1:0] off_x_reg, off_y_reg, off_z_reg;
    logic [LAT-1:0]                 vld_reg, vld_next;

    // Offset-corrected fields wait here for the trig pipeline.
    logic signed [DIFF_W-1:0] dx_reg [DLY];
    logic signed [DIFF_W-1:0] dy_reg [DLY];
    logic signed [DIFF_W-1:0] dz_reg [DLY];

    logic signed [TRIG_W-1:0] sin_r, cos_r, sin_p, cos_p;
    logic signed [PP_W-1:0]   prod_ss, prod_sc;

    logic signed [TRIG_W-1:0] spsr_reg, spcr_reg;
    logic signed [PROD_W-1:0] my_cr_reg, mz_sr_reg, mx_cp_reg;
    logic signed [DIFF_W-1:0] my_m1_reg, mz_m1_reg;

    logic signed [SUM_W-1:0]  a_reg;
    logic signed [PROD_W-1:0] my_spsr_reg, mz_spcr_reg, mx_cp2_reg;

    logic signed [VEC_W-1:0]  neg_a_reg, b_reg;
    logic signed [HEAD_W-1:0] h_angle;
    logic signed [HEAD_W-1:0] h_round;
    logic [RND_W-1:0]         r_val;
    logic [OUT_W-1:0]         heading_reg, heading_next;

    assign busy = 1'b0;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_OFFSET_X: off_x_reg <= cfg_data;
                REG_OFFSET_Y: off_y_reg <= cfg_data;
                REG_OFFSET_Z: off_z_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // One valid bit per pipeline stage travels alongside the data.
    assign vld_next = {vld_reg[LAT-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Hard-iron correction is exact at one bit wider than the samples.
    always_ff @(posedge clk)
    begin
        dx_reg[0] <= DIFF_W'(field_x) - DIFF_W'(off_x_reg);
        dy_reg[0] <= DIFF_W'(field_y) - DIFF_W'(off_y_reg);
        dz_reg[0] <= DIFF_W'(field_z) - DIFF_W'(off_z_reg);
        for (int k = 1; k < DLY; k++)
        begin
            dx_reg[k] <= dx_reg[k-1];
            dy_reg[k] <= dy_reg[k-1];
            dz_reg[k] <= dz_reg[k-1];
        end
    end

    tch_sincos #(.STEPS(CORDIC_STEPS)) u_roll
    (
        .clk     (clk),
        .angle   (roll_angle),
        .sin_val (sin_r),
        .cos_val (cos_r)
    );

    tch_sincos #(.STEPS(CORDIC_STEPS)) u_pitch
    (
        .clk     (clk),
        .angle   (pitch_angle),
        .sin_val (sin_p),
        .cos_val (cos_p)
    );

    assign prod_ss = PP_W'(sin_p) * PP_W'(sin_r);
    assign prod_sc = PP_W'(sin_p) * PP_W'(cos_r);

    // First multiply stage: the Q60 cross terms are shifted back to Q30 with
    // an arithmetic shift, i.e. truncated toward minus infinity.
    always_ff @(posedge clk)
    begin
        spsr_reg  <= prod_ss[TRIG_W+29:30];
        spcr_reg  <= prod_sc[TRIG_W+29:30];
        my_cr_reg <= PROD_W'(dy_reg[DLY-1]) * PROD_W'(cos_r);
        mz_sr_reg <= PROD_W'(dz_reg[DLY-1]) * PROD_W'(sin_r);
        mx_cp_reg <= PROD_W'(dx_reg[DLY-1]) * PROD_W'(cos_p);
        my_m1_reg <= dy_reg[DLY-1];
        mz_m1_reg <= dz_reg[DLY-1];
    end

    // Second stage: the a term is complete; the b products are formed.
    always_ff @(posedge clk)
    begin
        a_reg       <= SUM_W'(my_cr_reg) + SUM_W'(mz_sr_reg);
        my_spsr_reg <= PROD_W'(my_m1_reg) * PROD_W'(spsr_reg);
        mz_spcr_reg <= PROD_W'(mz_m1_reg) * PROD_W'(spcr_reg);
        mx_cp2_reg  <= mx_cp_reg;
    end

    // Third stage: b is summed and a is negated for atan2(-a, b).
    always_ff @(posedge clk)
    begin
        b_reg     <= VEC_W'(SUM_W'(mx_cp2_reg) + SUM_W'(my_spsr_reg) - SUM_W'(mz_spcr_reg));
        neg_a_reg <= -VEC_W'(a_reg);
    end

    tch_atan2 #(.STEPS(CORDIC_STEPS), .VEC_W(VEC_W)) u_atan2
    (
        .clk   (clk),
        .y_in  (neg_a_reg),
        .x_in  (b_reg),
        .angle (h_angle)
    );

    // Round half up from Q30 to Q13; a value that rounds to 2*pi wraps to zero.
    assign h_round = h_angle + H_ROUND_HALF;
    assign r_val   = h_round[HEAD_W-1:ANGLE_SHIFT];

    always_comb
    begin
        if (r_val > RND_W'(HEADING_MAX))
            heading_next = '0;
        else
            heading_next = r_val[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        heading_reg <= heading_next;
    end

    assign heading = heading_reg;
    assign done    = vld_reg[LAT-1];

`ifndef SYNTH
    // Every accepted transaction comes out as a done at the end of the pipeline.
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("transaction did not complete at the pipeline latency");

    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result produced with no matching transaction");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (heading <= HEADING_MAX))
        else $error("heading outside of [0, 2*pi)");
`endif

endmodule

// ===== sim/tb_tilt_compensated_heading.sv =====
// Self-checking testbench for the tilt-compensated heading pipeline.
// Depends on tch_pkg and the tilt_compensated_heading RTL; drives directed and random
// transactions, predicts every heading with a bit-exact CORDIC model and checks in order.
module tb_tilt_compensated_heading;
    import tch_pkg::*;

    localparam int STEPS    = DEF_CORDIC_STEPS;
    localparam int LATENCY  = 2 * STEPS + 8;
    localparam int WATCHDOG = 20000;

    // Q30 constants, and the largest Q13 heading, used by the predictor.
    localparam longint GAIN      = 64'sd652032874;
    localparam longint PI_Q30    = 64'sd3373259426;
    localparam longint HALFPI    = 64'sd1686629713;
    localparam longint TWOPI     = 64'sd6746518852;
    localparam longint HEAD_LAST = 64'sd51471;

    // One pending sample for the driver.
    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] fz;
    } sample_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic signed [15:0] field_z;
    logic cfg_write;
    cfg_index_t cfg_index;
    logic [15:0] cfg_data;
    logic done;
    logic [OUT_W-1:0] heading;

    tilt_compensated_heading dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .field_x(field_x), .field_y(field_y), .field_z(field_z),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .heading(heading)
    );

    // Samples waiting to be driven, and headings waiting to come back.
    sample_t         pending_samples[$];
    logic [15:0]     heading_queue[$];
    // Offsets as the predictor sees them; kept in step with every register write.
    logic signed [15:0] bias_x, bias_y, bias_z;
    int unsigned idle_pct;
    int error_count;
    int quiet_cycles;
    logic accepted_any;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Arithmetic shift right; SystemVerilog >>> on a signed longint already rounds
    // toward minus infinity.
    function automatic longint shr(longint v, int n);
        return v >>> n;
    endfunction

    // Sine and cosine of a Q30 angle by rotation-mode CORDIC.
    task automatic trig_q30(input longint theta, output longint s, output longint c);
        longint x, y, t, dx, dy;
        bit flip;
        x = GAIN;
        y = 0;
        t = theta;
        flip = 1'b0;
        if (t > HALFPI)
        begin
            t = t - PI_Q30;
            flip = 1'b1;
        end
        else if (t < -HALFPI)
        begin
            t = t + PI_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (t >= 0)
            begin
                x = x - dx; y = y + dy; t = t - longint'(ATAN_Q30[i]);
            end
            else
            begin
                x = x + dx; y = y - dy; t = t + longint'(ATAN_Q30[i]);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    // Angle of (xv, yv) by vectoring-mode CORDIC, Q30, in (-pi, pi].
    function automatic longint vector_angle(longint yv, longint xv);
        longint z, base, dx, dy;
        z = 0;
        base = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            base = (yv >= 0) ? PI_Q30 : -PI_Q30;
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = shr(yv, i);
            dy = shr(xv, i);
            if (yv < 0)
            begin
                xv = xv - dx; yv = yv + dy; z = z - longint'(ATAN_Q30[i]);
            end
            else
            begin
                xv = xv + dx; yv = yv - dy; z = z + longint'(ATAN_Q30[i]);
            end
        end
        return z + base;
    endfunction

    // Expected heading for one sample under the current offsets.
    task automatic predict_heading(input sample_t smp, output logic [15:0] result);
        longint roll, pitch, mx, my, mz, sr, cr, sp, cp, spsr, spcr, a, b, h, r;
        roll  = longint'($signed(smp.roll)) * 131072;
        pitch = longint'($signed(smp.pitch)) * 131072;
        mx = longint'($signed(smp.fx)) - longint'(bias_x);
        my = longint'($signed(smp.fy)) - longint'(bias_y);
        mz = longint'($signed(smp.fz)) - longint'(bias_z);
        trig_q30(roll, sr, cr);
        trig_q30(pitch, sp, cp);
        spsr = shr(sp * sr, 30);
        spcr = shr(sp * cr, 30);
        a = my * cr + mz * sr;
        b = mx * cp + my * spsr - mz * spcr;
        h = vector_angle(-a, b);
        if (h < 0)
            h = h + TWOPI;
        r = (h + 65536) >>> 17;
        if (r > HEAD_LAST || r < 0)
            r = 0;
        result = r[15:0];
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Driver: at each falling edge either offers the next sample or idles.
    // A transaction takes place at the next rising edge if start is high and busy low;
    // the expected heading is queued from the rising-edge sampler below.
    always @(negedge clk)
    begin
        if (rst_n && pending_samples.size() > 0 &&
            ($urandom_range(99, 0) >= idle_pct))
        begin
            start       <= 1'b1;
            roll_angle  <= pending_samples[0].roll;
            pitch_angle <= pending_samples[0].pitch;
            field_x     <= pending_samples[0].fx;
            field_y     <= pending_samples[0].fy;
            field_z     <= pending_samples[0].fz;
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // Monitor: takes accepted samples into the prediction and checks results.
    always @(posedge clk)
    begin
        logic [15:0] want;
        sample_t smp;
        accepted_any = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                accepted_any = 1'b1;
                if (heading_queue.size() == 0)
                    report_mismatch($sformatf("unexpected heading %0d", heading));
                else
                begin
                    want = heading_queue.pop_front();
                    if (heading !== want)
                        report_mismatch($sformatf("heading %0d, expected %0d",
                                                  heading, want));
                end
            end
            if (start && !busy)
            begin
                accepted_any = 1'b1;
                smp = pending_samples.pop_front();
                predict_heading(smp, want);
                heading_queue.push_back(want);
            end
            quiet_cycles = accepted_any ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("Watchdog expired with %0d headings outstanding",
                         heading_queue.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Extreme and special values mixed into the random data.
    function automatic logic [15:0] pick_field();
        case ($urandom_range(9, 0))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(16, 0)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(9, 0))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'd25736;
            3: return -16'sd25736;
            4: return 16'd12868;
            5: return 16'($urandom);
            default: return 16'($urandom_range(51472, 0) - 25736);
        endcase
    endfunction

    task automatic push_sample(input logic [15:0] r, input logic [15:0] p,
                               input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        sample_t s;
        s = '{roll: r, pitch: p, fx: x, fy: y, fz: z};
        pending_samples.push_back(s);
    endtask

    // Waits until every sample went in and every heading came out, then lets the
    // pipeline drain for its full latency so a register write cannot disturb it.
    task automatic drain();
        while (pending_samples.size() > 0 || heading_queue.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Register write at a falling edge, taken at the following rising edge.
    task automatic write_offset(input cfg_index_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_OFFSET_X: bias_x = value;
            REG_OFFSET_Y: bias_y = value;
            REG_OFFSET_Z: bias_z = value;
            default: ;
        endcase
    endtask

    initial
    begin
        int unsigned phase_idle[4];
        rst_n = 1'b0;
        start = 1'b0;
        roll_angle = '0;
        pitch_angle = '0;
        field_x = '0;
        field_y = '0;
        field_z = '0;
        cfg_write = 1'b0;
        cfg_index = REG_OFFSET_X;
        cfg_data = '0;
        bias_x = '0;
        bias_y = '0;
        bias_z = '0;
        idle_pct = 0;
        error_count = 0;
        quiet_cycles = 0;
        phase_idle = '{0, 74, 12, 0};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part with zero offsets: both terms zero, each quadrant so negative
        // b and the sign of -a are hit, angles beyond +-pi/2 and the raw extremes.
        push_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        push_sample(16'd0, 16'd0, 16'd1000, 16'd0, 16'd0);
        push_sample(16'd0, 16'd0, -16'sd1000, 16'd0, 16'd0);
        push_sample(16'd0, 16'd0, -16'sd1000, 16'd1, 16'd0);
        push_sample(16'd0, 16'd0, -16'sd1000, -16'sd1, 16'd0);
        push_sample(16'd0, 16'd0, 16'd1000, 16'd1000, 16'd0);
        push_sample(16'd0, 16'd0, 16'd1000, -16'sd1000, 16'd0);
        push_sample(16'd0, 16'd0, 16'd0, -16'sd1000, 16'd0);
        push_sample(16'd0, 16'd0, 16'd0, 16'd1000, 16'd0);
        // A tiny negative angle below zero that rounds up to two pi.
        push_sample(16'd0, 16'd0, 16'd32767, 16'd1, 16'd0);
        push_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_sample(16'd25736, -16'sd25736, 16'h7FFF, 16'h8000, 16'h7FFF);
        push_sample(-16'sd25736, 16'd25736, 16'h8000, 16'h7FFF, 16'h8000);
        push_sample(16'd12868, 16'd12868, 16'd500, 16'd700, 16'd900);
        push_sample(16'd12869, -16'sd12869, 16'd500, -16'sd700, 16'd900);
        push_sample(16'd20000, 16'd30000, 16'hFFFF, 16'h5555, 16'hAAAA);
        push_sample(16'hAAAA, 16'h5555, 16'h0001, 16'hFFFF, 16'h0000);
        drain();

        // Random phases, each under its own offset setting and sender idle rate.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin write_offset(REG_OFFSET_X, 16'h8000);
                         write_offset(REG_OFFSET_Y, 16'h7FFF);
                         write_offset(REG_OFFSET_Z, 16'h8000); end
                1: begin write_offset(REG_OFFSET_X, 16'h7FFF);
                         write_offset(REG_OFFSET_Y, 16'h8000);
                         write_offset(REG_OFFSET_Z, 16'h7FFF); end
                2: begin write_offset(REG_OFFSET_X, 16'd0);
                         write_offset(REG_OFFSET_Y, 16'd0);
                         write_offset(REG_OFFSET_Z, 16'd0); end
                default: begin write_offset(REG_OFFSET_X, 16'($urandom_range(4000, 0) - 2000));
                               write_offset(REG_OFFSET_Y, 16'($urandom));
                               write_offset(REG_OFFSET_Z, 16'($urandom_range(4000, 0) - 2000));
                         end
            endcase
            idle_pct = phase_idle[ph % 4];
            for (int n = 0; n < 142; n++)
            begin
                // Sometimes place the field right on the offsets so terms vanish.
                if ($urandom_range(19, 0) == 0)
                    push_sample(pick_angle(), pick_angle(), bias_x, bias_y, bias_z);
                else
                    push_sample(pick_angle(), pick_angle(), pick_field(), pick_field(),
                                pick_field());
                // Once, in the middle of phase 1, hold the sender until the pipeline is empty.
                if (n == 70 && ph == 1)
                    drain();
            end
            drain();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
